// ===== rtl/svpwm_pkg.sv =====
// Shared types and constants for the space vector PWM duty calculator.
// Depends on nothing; the stage modules, the top level and the testbench import it.
`default_nettype none

package svpwm_pkg;

    // 1/sqrt(3) in unsigned Q.24; 2/sqrt(3) is this value shifted left once
    localparam int          CONST_BITS  = 24;
    localparam logic [23:0] K_INV_SQRT3 = 24'd9686330;

    localparam int IN_W     = 16;
    localparam int DUTY_W   = 16;
    localparam int KB_W     = IN_W + CONST_BITS + 1;   // beta * 1/sqrt(3)
    localparam int NUM_W    = IN_W + CONST_BITS + 2;   // sector numerators
    localparam int PROD_W   = NUM_W + DUTY_W + 1;      // numerator * period
    localparam int TIME_W   = 28;                      // vector times and sums

    localparam logic [DUTY_W-1:0] DUTY_MAX = 16'hFFFF;

    // Configuration register indexes and reset values
    localparam int CFG_IDX_W = 1;
    typedef logic [CFG_IDX_W-1:0] cfg_index_t;
    localparam cfg_index_t REG_PWM_PERIOD = 1'd0;
    localparam cfg_index_t REG_MAX_MOD    = 1'd1;

    localparam logic [15:0] PWM_PERIOD_RST = 16'd3999;
    localparam logic [15:0] MAX_MOD_RST    = 16'd31130;

    // Sector codes
    typedef logic [2:0] sector_t;
    localparam sector_t SEC1 = 3'd1;
    localparam sector_t SEC2 = 3'd2;
    localparam sector_t SEC3 = 3'd3;
    localparam sector_t SEC4 = 3'd4;
    localparam sector_t SEC5 = 3'd5;
    localparam sector_t SEC6 = 3'd6;

    typedef struct packed {
        sector_t                  sector;
        logic signed [NUM_W-1:0]  num_x;
        logic signed [NUM_W-1:0]  num_y;
    } sec_pl_t;

    typedef struct packed {
        sector_t                  sector;
        logic signed [TIME_W-1:0] x;
        logic signed [TIME_W-1:0] y;
    } time_pl_t;

endpackage

`default_nettype wire

// ===== rtl/svpwm_in_if.sv =====
// Input channel of the duty calculator: alpha/beta voltage transaction.
// Standalone valid/ready interface, no dependencies.
`default_nettype none

interface svpwm_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] alpha;
    logic signed [15:0] beta;

    modport source (output valid, output alpha, output beta, input ready);
    modport sink   (input valid, input alpha, input beta, output ready);
endinterface

`default_nettype wire

// ===== rtl/svpwm_out_if.sv =====
// Output channel of the duty calculator: three compare counts and the sector.
// Standalone valid/ready interface, no dependencies.
`default_nettype none

interface svpwm_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] duty_a;
    logic [15:0] duty_b;
    logic [15:0] duty_c;
    logic [2:0]  sector_num;

    modport source (output valid, output duty_a, output duty_b, output duty_c,
                    output sector_num, input ready);
    modport sink   (input valid, input duty_a, input duty_b, input duty_c,
                    input sector_num, output ready);
endinterface

`default_nettype wire

// ===== rtl/svpwm_sector.sv =====
// Two pipeline stages: beta/sqrt(3) product, then sector decision and
// selection of the two active vector numerators. Uses svpwm_pkg.
`default_nettype none

module svpwm_sector
    import svpwm_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic signed [IN_W-1:0] alpha,
    input  wire logic signed [IN_W-1:0] beta,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output sec_pl_t                     out_data
);

    // Stage A
    logic                   a_valid_reg;
    logic                   a_ready;
    logic signed [IN_W-1:0] alpha_reg;
    logic signed [KB_W-1:0] kb_reg;
    logic signed [KB_W-1:0] kb_next;
    logic                   beta_neg_reg;

    // Stage B
    logic                    b_valid_reg;
    logic                    b_ready;
    sec_pl_t                 b_data_reg;
    sec_pl_t                 b_data_next;
    logic signed [NUM_W-1:0] a_ext;
    logic signed [NUM_W-1:0] kb_ext;
    logic signed [NUM_W-1:0] amk;
    logic signed [NUM_W-1:0] apk;
    logic signed [NUM_W-1:0] k2b;
    sector_t                 sector;

    assign a_ready  = !a_valid_reg || b_ready;
    assign b_ready  = !b_valid_reg || out_ready;
    assign in_ready = a_ready;

    assign kb_next = $signed({1'b0, K_INV_SQRT3}) * beta;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            alpha_reg    <= alpha;
            kb_reg       <= kb_next;
            beta_neg_reg <= beta[IN_W-1];
        end
        if (b_ready && a_valid_reg)
        begin
            b_data_reg <= b_data_next;
        end
    end

    // kb > a is the sign of a - kb; -kb > a is the sign of a + kb
    always_comb
    begin
        a_ext  = {{(NUM_W-IN_W-CONST_BITS){alpha_reg[IN_W-1]}}, alpha_reg,
                  {CONST_BITS{1'b0}}};
        kb_ext = {{(NUM_W-KB_W){kb_reg[KB_W-1]}}, kb_reg};
        amk    = a_ext - kb_ext;
        apk    = a_ext + kb_ext;
        k2b    = kb_ext <<< 1;

        if (!beta_neg_reg)
        begin
            if (!alpha_reg[IN_W-1])
                sector = amk[NUM_W-1] ? SEC2 : SEC1;
            else
                sector = apk[NUM_W-1] ? SEC3 : SEC2;
        end
        else
        begin
            if (!alpha_reg[IN_W-1])
                sector = apk[NUM_W-1] ? SEC5 : SEC6;
            else
                sector = amk[NUM_W-1] ? SEC4 : SEC5;
        end

        b_data_next.sector = sector;
        case (sector)
            SEC1:
            begin
                b_data_next.num_x = amk;
                b_data_next.num_y = k2b;
            end
            SEC2:
            begin
                b_data_next.num_x = apk;
                b_data_next.num_y = -amk;
            end
            SEC3:
            begin
                b_data_next.num_x = k2b;
                b_data_next.num_y = -apk;
            end
            SEC4:
            begin
                b_data_next.num_x = -amk;
                b_data_next.num_y = -k2b;
            end
            SEC5:
            begin
                b_data_next.num_x = -apk;
                b_data_next.num_y = amk;
            end
            SEC6:
            begin
                b_data_next.num_x = -k2b;
                b_data_next.num_y = apk;
            end
            default:
            begin
                b_data_next.num_x = '0;
                b_data_next.num_y = '0;
            end
        endcase
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

endmodule

`default_nettype wire

// ===== rtl/svpwm_scale.sv =====
// Two pipeline stages: scale both numerators by the PWM period, then drop
// the fraction bits with truncation toward zero. Uses svpwm_pkg.
`default_nettype none

module svpwm_scale
    import svpwm_pkg::*;
#(
    parameter int FRAC_BITS = 15
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [DUTY_W-1:0] pwm_period,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire sec_pl_t           in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output time_pl_t               out_data
);

    localparam int SHIFT = FRAC_BITS + CONST_BITS;
    localparam logic [PROD_W-1:0] RND_BIAS = {{(PROD_W-SHIFT){1'b0}}, {SHIFT{1'b1}}};

    // Stage C
    logic                     c_valid_reg;
    logic                     c_ready;
    sector_t                  c_sector_reg;
    logic signed [PROD_W-1:0] prod_x_reg;
    logic signed [PROD_W-1:0] prod_y_reg;
    logic signed [PROD_W-1:0] prod_x_next;
    logic signed [PROD_W-1:0] prod_y_next;
    logic signed [DUTY_W:0]   p_signed;

    // Stage D
    logic                     d_valid_reg;
    logic                     d_ready;
    time_pl_t                 d_data_reg;
    time_pl_t                 d_data_next;
    logic signed [PROD_W-1:0] sum_x;
    logic signed [PROD_W-1:0] sum_y;
    logic signed [PROD_W-1:0] quo_x;
    logic signed [PROD_W-1:0] quo_y;

    assign c_ready  = !c_valid_reg || d_ready;
    assign d_ready  = !d_valid_reg || out_ready;
    assign in_ready = c_ready;

    assign p_signed    = $signed({1'b0, pwm_period});
    assign prod_x_next = in_data.num_x * p_signed;
    assign prod_y_next = in_data.num_y * p_signed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            if (c_ready)
            begin
                c_valid_reg <= in_valid;
            end
            if (d_ready)
            begin
                d_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_ready && in_valid)
        begin
            c_sector_reg <= in_data.sector;
            prod_x_reg   <= prod_x_next;
            prod_y_reg   <= prod_y_next;
        end
        if (d_ready && c_valid_reg)
        begin
            d_data_reg <= d_data_next;
        end
    end

    // Bias negative products so the arithmetic shift rounds toward zero
    always_comb
    begin
        sum_x = prod_x_reg + ({PROD_W{prod_x_reg[PROD_W-1]}} & RND_BIAS);
        sum_y = prod_y_reg + ({PROD_W{prod_y_reg[PROD_W-1]}} & RND_BIAS);
        quo_x = sum_x >>> SHIFT;
        quo_y = sum_y >>> SHIFT;
        d_data_next.sector = c_sector_reg;
        d_data_next.x      = quo_x[TIME_W-1:0];
        d_data_next.y      = quo_y[TIME_W-1:0];
    end

    assign out_valid = d_valid_reg;
    assign out_data  = d_data_reg;

endmodule

`default_nettype wire

// ===== rtl/svpwm_duty.sv =====
// Three pipeline stages: centered first time, the two following times, then
// clamp and phase mapping into the output register. Uses svpwm_pkg.
`default_nettype none

module svpwm_duty
    import svpwm_pkg::*;
#(
    parameter int FRAC_BITS = 15
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [DUTY_W-1:0] pwm_period,
    input  wire logic [15:0]       max_mod,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire time_pl_t          in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [DUTY_W-1:0]      duty_a,
    output logic [DUTY_W-1:0]      duty_b,
    output logic [DUTY_W-1:0]      duty_c,
    output sector_t                sector_num
);

    localparam int SCALE_W = ((FRAC_BITS > 16) ? FRAC_BITS : 16) + 1;
    localparam int TP_W    = DUTY_W + SCALE_W;

    // Upper clamp, recomputed from the configuration every cycle
    logic [SCALE_W-1:0] scale;
    logic [TP_W-1:0]    tmax_prod_reg;
    logic [TP_W-1:0]    tmax_prod_next;
    logic [TP_W-1:0]    tmax_full;
    logic [DUTY_W-1:0]  limit_reg;
    logic [DUTY_W-1:0]  limit_next;

    // Stage E
    logic                     e_valid_reg;
    logic                     e_ready;
    sector_t                  e_sector_reg;
    logic signed [TIME_W-1:0] e_x_reg;
    logic signed [TIME_W-1:0] e_y_reg;
    logic signed [TIME_W-1:0] e_first_reg;
    logic signed [TIME_W-1:0] tot;
    logic signed [TIME_W-1:0] tot_adj;

    // Stage F
    logic                     f_valid_reg;
    logic                     f_ready;
    sector_t                  f_sector_reg;
    logic signed [TIME_W-1:0] f_first_reg;
    logic signed [TIME_W-1:0] f_second_reg;
    logic signed [TIME_W-1:0] f_third_reg;

    // Stage G (output register)
    logic                     g_valid_reg;
    logic                     g_ready;
    logic [DUTY_W-1:0]        cl_first;
    logic [DUTY_W-1:0]        cl_second;
    logic [DUTY_W-1:0]        cl_third;
    logic [DUTY_W-1:0]        duty_a_reg;
    logic [DUTY_W-1:0]        duty_b_reg;
    logic [DUTY_W-1:0]        duty_c_reg;
    logic [DUTY_W-1:0]        duty_a_next;
    logic [DUTY_W-1:0]        duty_b_next;
    logic [DUTY_W-1:0]        duty_c_next;
    sector_t                  sector_reg;

    function automatic logic [DUTY_W-1:0] clamp_duty(
        input logic signed [TIME_W-1:0] t,
        input logic [DUTY_W-1:0]        lim
    );
        logic signed [TIME_W-1:0] lim_ext;
        lim_ext = $signed({{(TIME_W-DUTY_W){1'b0}}, lim});
        if (t[TIME_W-1])
            return '0;
        else if (t > lim_ext)
            return lim;
        else
            return t[DUTY_W-1:0];
    endfunction

    always_comb
    begin
        scale          = (SCALE_W'(1) << FRAC_BITS) + SCALE_W'(max_mod);
        tmax_prod_next = TP_W'(pwm_period) * TP_W'(scale);
        tmax_full      = tmax_prod_reg >> (FRAC_BITS + 1);
        limit_next     = (|tmax_full[TP_W-1:DUTY_W]) ? DUTY_MAX : tmax_full[DUTY_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        tmax_prod_reg <= tmax_prod_next;
        limit_reg     <= limit_next;
    end

    assign e_ready  = !e_valid_reg || f_ready;
    assign f_ready  = !f_valid_reg || g_ready;
    assign g_ready  = !g_valid_reg || out_ready;
    assign in_ready = e_ready;

    // Halve the sum with truncation toward zero
    always_comb
    begin
        tot     = $signed({{(TIME_W-DUTY_W){1'b0}}, pwm_period}) + in_data.x + in_data.y;
        tot_adj = tot + $signed({{(TIME_W-1){1'b0}}, tot[TIME_W-1]});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
        end
        else
        begin
            if (e_ready)
            begin
                e_valid_reg <= in_valid;
            end
            if (f_ready)
            begin
                f_valid_reg <= e_valid_reg;
            end
            if (g_ready)
            begin
                g_valid_reg <= f_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (e_ready && in_valid)
        begin
            e_sector_reg <= in_data.sector;
            e_x_reg      <= in_data.x;
            e_y_reg      <= in_data.y;
            e_first_reg  <= tot_adj >>> 1;
        end
        // Odd sectors step down by x first, even sectors by y
        if (f_ready && e_valid_reg)
        begin
            f_sector_reg <= e_sector_reg;
            f_first_reg  <= e_first_reg;
            f_second_reg <= e_first_reg - (e_sector_reg[0] ? e_x_reg : e_y_reg);
            f_third_reg  <= e_first_reg - e_x_reg - e_y_reg;
        end
        if (g_ready && f_valid_reg)
        begin
            duty_a_reg <= duty_a_next;
            duty_b_reg <= duty_b_next;
            duty_c_reg <= duty_c_next;
            sector_reg <= f_sector_reg;
        end
    end

    always_comb
    begin
        cl_first  = clamp_duty(f_first_reg, limit_reg);
        cl_second = clamp_duty(f_second_reg, limit_reg);
        cl_third  = clamp_duty(f_third_reg, limit_reg);
        case (f_sector_reg)
            SEC1:
            begin
                duty_a_next = cl_first;
                duty_b_next = cl_second;
                duty_c_next = cl_third;
            end
            SEC2:
            begin
                duty_b_next = cl_first;
                duty_a_next = cl_second;
                duty_c_next = cl_third;
            end
            SEC3:
            begin
                duty_b_next = cl_first;
                duty_c_next = cl_second;
                duty_a_next = cl_third;
            end
            SEC4:
            begin
                duty_c_next = cl_first;
                duty_b_next = cl_second;
                duty_a_next = cl_third;
            end
            SEC5:
            begin
                duty_c_next = cl_first;
                duty_a_next = cl_second;
                duty_b_next = cl_third;
            end
            default:
            begin
                duty_a_next = cl_first;
                duty_c_next = cl_second;
                duty_b_next = cl_third;
            end
        endcase
    end

    assign out_valid  = g_valid_reg;
    assign duty_a     = duty_a_reg;
    assign duty_b     = duty_b_reg;
    assign duty_c     = duty_c_reg;
    assign sector_num = sector_reg;

endmodule

`default_nettype wire

// ===== rtl/svpwm_duty_calculator.sv =====
// Seven-segment space vector PWM duty calculator, top level.
// An accepted vector passes through stage registers A to G before its result reaches the output.
// Throughput: one vector per cycle; seven register stages, each stalled only
// when its successor is full, the deepest logic being one 42x17 multiply.
// Reset clears all stage valid bits; pwm_period resets to 3999, max_mod to 31130.
// Depends on svpwm_pkg, svpwm_in_if, svpwm_out_if and the three stage modules.
`default_nettype none

module svpwm_duty_calculator
    import svpwm_pkg::*;
#(
    parameter int FRAC_BITS = 15
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire cfg_index_t        cfg_index,
    input  wire logic [15:0]       cfg_data,
    svpwm_in_if.sink               vec,
    svpwm_out_if.source            duty
);

    logic [DUTY_W-1:0] pwm_period_reg;
    logic [15:0]       max_mod_reg;

    logic     sec_valid;
    logic     sec_ready;
    sec_pl_t  sec_data;
    logic     time_valid;
    logic     time_ready;
    time_pl_t time_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm_period_reg <= PWM_PERIOD_RST;
            max_mod_reg    <= MAX_MOD_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_PWM_PERIOD: pwm_period_reg <= cfg_data;
                REG_MAX_MOD:    max_mod_reg    <= cfg_data;
            endcase
        end
    end

    svpwm_sector u_sector (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vec.valid),
        .in_ready  (vec.ready),
        .alpha     (vec.alpha),
        .beta      (vec.beta),
        .out_valid (sec_valid),
        .out_ready (sec_ready),
        .out_data  (sec_data)
    );

    svpwm_scale #(
        .FRAC_BITS (FRAC_BITS)
    ) u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .pwm_period (pwm_period_reg),
        .in_valid   (sec_valid),
        .in_ready   (sec_ready),
        .in_data    (sec_data),
        .out_valid  (time_valid),
        .out_ready  (time_ready),
        .out_data   (time_data)
    );

    svpwm_duty #(
        .FRAC_BITS (FRAC_BITS)
    ) u_duty (
        .clk        (clk),
        .rst_n      (rst_n),
        .pwm_period (pwm_period_reg),
        .max_mod    (max_mod_reg),
        .in_valid   (time_valid),
        .in_ready   (time_ready),
        .in_data    (time_data),
        .out_valid  (duty.valid),
        .out_ready  (duty.ready),
        .duty_a     (duty.duty_a),
        .duty_b     (duty.duty_b),
        .duty_c     (duty.duty_c),
        .sector_num (duty.sector_num)
    );

endmodule

`default_nettype wire

// ===== tb/sv/svpwm_duty_calculator_checker.sv =====
`timescale 1ns / 100ps
// Checker for the SVPWM duty calculator: predicts the sector and the three compare counts
// of every accepted voltage vector and compares them in order with the output transactions.
// Depends on svpwm_pkg, svpwm_in_if and svpwm_out_if.

module svpwm_duty_calculator_checker
    import svpwm_pkg::*;
#(
    parameter int FRAC_BITS = 15
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire cfg_index_t  cfg_index,
    input  wire logic [15:0] cfg_data,
    svpwm_in_if              vec,
    svpwm_out_if             duty,
    output int               fail_count,
    output int               pending,
    output int               checked
);

    typedef struct packed {
        logic [15:0] duty_a;
        logic [15:0] duty_b;
        logic [15:0] duty_c;
        sector_t     sector;
    } duty_set_t;

    localparam longint Q24_ONE   = longint'(1) << CONST_BITS;
    localparam longint SCALE_ONE = longint'(1) << (FRAC_BITS + CONST_BITS);

    logic [15:0] period_q  = PWM_PERIOD_RST;
    logic [15:0] max_mod_q = MAX_MOD_RST;
    duty_set_t   duty_sets_due[$];

    initial
    begin
        fail_count = 0;
        pending    = 0;
        checked    = 0;
    end

    // Vector time scaled by the period, truncated toward zero once
    function automatic longint period_time(input longint num, input longint period);
        return (num * period) / SCALE_ONE;
    endfunction

    function automatic logic [15:0] clamp_count(input longint t, input longint t_max);
        longint v;
        v = t;
        if (v < 0)
            v = 0;
        else if (v > t_max)
            v = t_max;
        if (v > longint'(DUTY_MAX))
            v = longint'(DUTY_MAX);
        return v[15:0];
    endfunction

    function automatic duty_set_t predict_duty(input logic signed [15:0] alpha,
                                               input logic signed [15:0] beta);
        longint    a, kb, k2b, p, x, y, ta, tb, tc, t_max;
        sector_t   sec;
        duty_set_t r;
        p   = longint'(period_q);
        a   = longint'(alpha) * Q24_ONE;
        kb  = longint'(K_INV_SQRT3) * longint'(beta);
        k2b = 2 * kb;

        // Ties on the beta/sqrt(3) line fall to the lower branch
        if (beta >= 0)
        begin
            if (alpha >= 0)
                sec = (kb > a) ? SEC2 : SEC1;
            else
                sec = (-kb > a) ? SEC3 : SEC2;
        end
        else
        begin
            if (alpha >= 0)
                sec = (-kb > a) ? SEC5 : SEC6;
            else
                sec = (kb > a) ? SEC4 : SEC5;
        end

        case (sec)
            SEC1:
            begin
                x  = period_time(a - kb, p);
                y  = period_time(k2b, p);
                ta = (p + x + y) / 2;
                tb = ta - x;
                tc = tb - y;
            end
            SEC2:
            begin
                x  = period_time(a + kb, p);
                y  = period_time(-a + kb, p);
                tb = (p + x + y) / 2;
                ta = tb - y;
                tc = ta - x;
            end
            SEC3:
            begin
                x  = period_time(k2b, p);
                y  = period_time(-a - kb, p);
                tb = (p + x + y) / 2;
                tc = tb - x;
                ta = tc - y;
            end
            SEC4:
            begin
                x  = period_time(-a + kb, p);
                y  = period_time(-k2b, p);
                tc = (p + x + y) / 2;
                tb = tc - y;
                ta = tb - x;
            end
            SEC5:
            begin
                x  = period_time(-a - kb, p);
                y  = period_time(a - kb, p);
                tc = (p + x + y) / 2;
                ta = tc - x;
                tb = ta - y;
            end
            default:
            begin
                x  = period_time(-k2b, p);
                y  = period_time(a + kb, p);
                ta = (p + x + y) / 2;
                tc = ta - y;
                tb = tc - x;
            end
        endcase

        t_max = (p * ((longint'(1) << FRAC_BITS) + longint'(max_mod_q))) >>> (FRAC_BITS + 1);

        r.duty_a = clamp_count(ta, t_max);
        r.duty_b = clamp_count(tb, t_max);
        r.duty_c = clamp_count(tc, t_max);
        r.sector = sec;
        return r;
    endfunction

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Compare before queuing: a result can never belong to a vector taken at the same edge
    always @(posedge clk or negedge rst_n)
    begin : watch
        duty_set_t want;
        if (!rst_n)
        begin
            period_q  = PWM_PERIOD_RST;
            max_mod_q = MAX_MOD_RST;
            duty_sets_due.delete();
            pending   = 0;
        end
        else
        begin
            if (duty.valid && duty.ready)
            begin
                if (duty_sets_due.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected duty transaction, expected none, actual %0d/%0d/%0d s%0d",
                             $time, duty.duty_a, duty.duty_b, duty.duty_c, duty.sector_num);
                end
                else
                begin
                    want = duty_sets_due.pop_front();
                    compare_field("duty_a", want.duty_a, duty.duty_a);
                    compare_field("duty_b", want.duty_b, duty.duty_b);
                    compare_field("duty_c", want.duty_c, duty.duty_c);
                    compare_field("sector_num", want.sector, duty.sector_num);
                    checked++;
                end
            end
            if (vec.valid && vec.ready)
                duty_sets_due.push_back(predict_duty(vec.alpha, vec.beta));
            if (cfg_wr_en)
            begin
                if (cfg_index == REG_PWM_PERIOD)
                    period_q = cfg_data;
                else if (cfg_index == REG_MAX_MOD)
                    max_mod_q = cfg_data;
            end
            pending = duty_sets_due.size();
        end
    end

endmodule

// ===== tb/sv/svpwm_duty_calculator_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the SVPWM duty calculator: drives voltage vectors, register settings
// and output backpressure; svpwm_duty_calculator_checker does the prediction and comparison.
// Depends on svpwm_pkg, both channel interfaces, the block and the checker.

module svpwm_duty_calculator_tb;
    import svpwm_pkg::*;

    localparam int FRAC_BITS  = 15;
    localparam int IDLE_LIMIT = 3000;
    localparam int HOLD_LEN   = 150;
    localparam int N_EDGE     = 19;

    // Extremes, axis crossings and vectors just either side of the 60 degree lines
    localparam logic signed [15:0] EDGE_ALPHA [N_EDGE] = '{
        16'sd0, 16'sd32767, -16'sd32768, 16'sd0, 16'sd0, 16'sd32767, -16'sd32768,
        16'sd32767, -16'sd32768, 16'sd10000, 16'sd10000, -16'sd10000, -16'sd10000,
        16'sd10000, 16'sd10000, -16'sd10000, -16'sd10000, -16'sd1, 16'sd0};
    localparam logic signed [15:0] EDGE_BETA [N_EDGE] = '{
        16'sd0, 16'sd0, 16'sd0, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768,
        -16'sd32768, 16'sd32767, 16'sd17320, 16'sd17321, 16'sd17320, 16'sd17321,
        -16'sd17320, -16'sd17321, -16'sd17320, -16'sd17321, 16'sd0, -16'sd1};

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wr_en;
    cfg_index_t  cfg_index;
    logic [15:0] cfg_data;

    int fail_count;
    int pending;
    int checked;

    bit tx_gaps  = 1'b1;
    bit rx_gaps  = 1'b1;
    bit hold_req = 1'b0;
    int vectors_sent = 0;
    int settings_used = 1;
    int idle_cycles = 0;
    int stall_left = 0;

    svpwm_in_if  vec_if();
    svpwm_out_if duty_if();

    svpwm_duty_calculator #(.FRAC_BITS(FRAC_BITS)) uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .vec       (vec_if),
        .duty      (duty_if)
    );

    svpwm_duty_calculator_checker #(.FRAC_BITS(FRAC_BITS)) checker_i
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .vec        (vec_if),
        .duty       (duty_if),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Mostly no gap, sometimes a few cycles, rarely a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Output side: random stalls, plus one long hold-off on request
    initial
    begin
        duty_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                duty_if.ready <= 1'b0;
            else if (stall_left > 0)
            begin
                duty_if.ready <= 1'b0;
                stall_left--;
            end
            else if (hold_req)
            begin
                hold_req = 1'b0;
                stall_left = HOLD_LEN - 1;
                duty_if.ready <= 1'b0;
            end
            else
            begin
                duty_if.ready <= 1'b1;
                if (rx_gaps && $urandom_range(0, 99) < 30)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((vec_if.valid && vec_if.ready) || (duty_if.valid && duty_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
                $display("svpwm_duty_calculator_tb: done, errors");
                $finish;
            end
        end
    end

    // Call at a rising edge; returns at a rising edge
    task automatic send_vec(input logic signed [15:0] alpha, input logic signed [15:0] beta);
        int gap;
        vec_if.valid <= 1'b1;
        vec_if.alpha <= alpha;
        vec_if.beta  <= beta;
        @(posedge clk);
        while (!vec_if.ready)
            @(posedge clk);
        vectors_sent++;
        gap = tx_gaps ? pick_gap() : 0;
        if (gap > 0)
        begin
            vec_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic pick_vector(output logic signed [15:0] alpha, output logic signed [15:0] beta);
        int kind, m, a, b, jitter;
        kind = $urandom_range(0, 9);
        if (kind < 4)
        begin
            a = $urandom;
            b = $urandom;
        end
        else if (kind < 6)
        begin
            a = $urandom_range(0, 200);
            b = $urandom_range(0, 200);
            a -= 100;
            b -= 100;
        end
        else if (kind < 9)
        begin
            // hug a sector border: beta close to sqrt(3) * alpha
            m = $urandom_range(0, 18000);
            jitter = $urandom_range(0, 8);
            jitter -= 4;
            a = m;
            b = (m * 1732) / 1000 + jitter;
            if ($urandom_range(0, 1))
                a = -a;
            if ($urandom_range(0, 1))
                b = -b;
        end
        else
        begin
            case ($urandom_range(0, 4))
                0: a = 32767;
                1: a = -32768;
                2: a = 0;
                3: a = -1;
                default: a = 1;
            endcase
            case ($urandom_range(0, 4))
                0: b = 32767;
                1: b = -32768;
                2: b = 0;
                3: b = -1;
                default: b = 1;
            endcase
        end
        alpha = a[15:0];
        beta  = b[15:0];
    endtask

    task automatic send_random(input int count);
        logic signed [15:0] alpha, beta;
        repeat (count)
        begin
            pick_vector(alpha, beta);
            send_vec(alpha, beta);
        end
    endtask

    // Stop offering, let the checker see the last transaction, then wait for every result
    task automatic drain();
        vec_if.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t index, input logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [15:0] period, input logic [15:0] max_mod);
        drain();
        write_reg(REG_PWM_PERIOD, period);
        write_reg(REG_MAX_MOD, max_mod);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    task automatic run_phase(input logic [15:0] period, input logic [15:0] max_mod,
                             input int count, input bit tx_idle, input bit rx_idle);
        set_config(period, max_mod);
        tx_gaps = tx_idle;
        rx_gaps = rx_idle;
        send_random(count);
    endtask

    initial
    begin : stimulus
        rst_n = 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_index    <= REG_PWM_PERIOD;
        cfg_data     <= '0;
        vec_if.valid <= 1'b0;
        vec_if.alpha <= '0;
        vec_if.beta  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings first
        for (int i = 0; i < N_EDGE; i++)
            send_vec(EDGE_ALPHA[i], EDGE_BETA[i]);
        send_random(150);

        // widest period, clamp limit equal to the period; fill the pipe against a held output
        set_config(16'hFFFF, 16'd32768);
        hold_req = 1'b1;
        tx_gaps  = 1'b0;
        send_random(40);
        tx_gaps  = 1'b1;
        drain();
        send_random(80);

        run_phase(16'd1, 16'd0, 80, 1'b0, 1'b0);
        run_phase(16'd0, 16'hFFFF, 60, 1'b1, 1'b1);
        run_phase(16'd50000, 16'hFFFF, 80, 1'b1, 1'b0);
        repeat (3)
            run_phase(16'($urandom_range(1, 65535)), 16'($urandom_range(0, 32768)), 80,
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        run_phase(16'd2000, 16'd16384, 100, 1'b1, 1'b1);

        drain();
        repeat (20) @(posedge clk);

        $display("svpwm_duty_calculator_tb: %0d vectors over %0d register settings,",
                 vectors_sent, settings_used);
        $display("  %0d results compared (all sectors, field extremes, zero period,", checked);
        $display("  saturating limit, long output hold)");
        if (fail_count == 0)
            $display("svpwm_duty_calculator_tb: done, clean");
        else
            $display("svpwm_duty_calculator_tb: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/svpwm_pkg.sv
rtl/svpwm_in_if.sv
rtl/svpwm_out_if.sv
rtl/svpwm_sector.sv
rtl/svpwm_scale.sv
rtl/svpwm_duty.sv
rtl/svpwm_duty_calculator.sv
tb/sv/svpwm_duty_calculator_checker.sv
tb/sv/svpwm_duty_calculator_tb.sv
